### rtl/core/symbol_name_checker_macros.svh
// ----------------------------------------------------------------------------
// Symbol name checker assertion macros
// Shorthand for clocked, reset-qualified implication properties.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_NAME_CHECKER_MACROS_SVH
`define SYMBOL_NAME_CHECKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SNC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/snc_pkg.sv
// ----------------------------------------------------------------------------
// Symbol name checker package
// Parser states, character constants and the per-byte transition function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package snc_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_RBR   = 8'h5D;
	localparam logic [7:0] CH_USCR  = 8'h5F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_DOL   = 8'h24;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_BTICK = 8'h60;
	localparam logic [7:0] CH_QUES  = 8'h3F;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SQUOT = 8'h27;

	typedef enum logic [4:0] {
		ST_START     = 5'd0,
		ST_DONE      = 5'd1,
		ST_LT        = 5'd2,
		ST_LE        = 5'd3,
		ST_GT        = 5'd4,
		ST_EQ        = 5'd5,
		ST_EQEQ      = 5'd6,
		ST_STAR      = 5'd7,
		ST_BANG      = 5'd8,
		ST_PM        = 5'd9,
		ST_BAR       = 5'd10,
		ST_AMP       = 5'd11,
		ST_LBR       = 5'd12,
		ST_BRK       = 5'd13,
		ST_ID_LOCAL  = 5'd14,
		ST_ID_CONST  = 5'd15,
		ST_AT        = 5'd16,
		ST_ID_FIRST  = 5'd17,
		ST_DOL       = 5'd18,
		ST_DOL_DASH  = 5'd19,
		ST_DOL_DIG   = 5'd20,
		ST_FAIL      = 5'd31
	} parse_state_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= 8'h39);
	endfunction

	function automatic logic is_id_start(input logic [7:0] c);
		return is_upper(c) || is_lower(c) || (c == CH_USCR);
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_id_start(c) || is_digit(c);
	endfunction

	function automatic logic is_global_punct(input logic [7:0] c);
		return (c == CH_TILDE) || (c == CH_STAR) || (c == CH_DOL) || (c == CH_QUES) ||
			(c == CH_BANG) || (c == CH_AT) || (c == CH_SLASH) || (c == CH_BSL) ||
			(c == CH_SEMI) || (c == CH_COMMA) || (c == CH_DOT) || (c == CH_EQ) ||
			(c == CH_COLON) || (c == CH_LT) || (c == CH_GT) || (c == CH_DQUOT) ||
			(c == CH_AMP) || (c == CH_BTICK) || (c == CH_SQUOT) || (c == CH_PLUS) ||
			(c == CH_ZERO);
	endfunction

	function automatic parse_state_t start_step(input logic [7:0] c);
		parse_state_t n;
		if (c == CH_DOL) n = ST_DOL;
		else if (c == CH_AT) n = ST_AT;
		else if (c == CH_LT) n = ST_LT;
		else if (c == CH_GT) n = ST_GT;
		else if (c == CH_EQ) n = ST_EQ;
		else if (c == CH_STAR) n = ST_STAR;
		else if (c == CH_BANG) n = ST_BANG;
		else if ((c == CH_PLUS) || (c == CH_DASH)) n = ST_PM;
		else if (c == CH_BAR) n = ST_BAR;
		else if (c == CH_AMP) n = ST_AMP;
		else if ((c == CH_CARET) || (c == CH_SLASH) || (c == CH_PCT) ||
			(c == CH_TILDE) || (c == CH_BTICK)) n = ST_DONE;
		else if (c == CH_LBR) n = ST_LBR;
		else if (is_upper(c)) n = ST_ID_CONST;
		else if (is_id_start(c)) n = ST_ID_LOCAL;
		else n = ST_FAIL;
		return n;
	endfunction

	function automatic parse_state_t next_state(input parse_state_t s, input logic [7:0] c);
		parse_state_t n;
		n = ST_FAIL;
		unique case (s)
			ST_START: n = start_step(c);
			ST_LT: begin
				if (c == CH_LT) n = ST_DONE;
				else if (c == CH_EQ) n = ST_LE;
			end
			ST_LE: if (c == CH_GT) n = ST_DONE;
			ST_GT: if ((c == CH_GT) || (c == CH_EQ)) n = ST_DONE;
			ST_EQ: begin
				if (c == CH_TILDE) n = ST_DONE;
				else if (c == CH_EQ) n = ST_EQEQ;
			end
			ST_EQEQ: if (c == CH_EQ) n = ST_DONE;
			ST_STAR: if (c == CH_STAR) n = ST_DONE;
			ST_BANG: if ((c == CH_EQ) || (c == CH_TILDE)) n = ST_DONE;
			ST_PM: if (c == CH_AT) n = ST_DONE;
			ST_BAR: if (c == CH_BAR) n = ST_DONE;
			ST_AMP: if (c == CH_AMP) n = ST_DONE;
			ST_LBR: if (c == CH_RBR) n = ST_BRK;
			ST_BRK: if (c == CH_EQ) n = ST_DONE;
			ST_ID_LOCAL: begin
				if (is_ident(c)) n = ST_ID_LOCAL;
				else if ((c == CH_BANG) || (c == CH_QUES) || (c == CH_EQ)) n = ST_DONE;
			end
			ST_ID_CONST: if (is_ident(c)) n = ST_ID_CONST;
			ST_AT: begin
				if (c == CH_AT) n = ST_ID_FIRST;
				else if (is_id_start(c)) n = ST_ID_CONST;
			end
			ST_ID_FIRST: if (is_id_start(c)) n = ST_ID_CONST;
			ST_DOL: begin
				if (is_global_punct(c)) n = ST_DONE;
				else if (c == CH_DASH) n = ST_DOL_DASH;
				else if (is_digit(c)) n = ST_DOL_DIG;
				else if (is_id_start(c)) n = ST_ID_CONST;
			end
			ST_DOL_DASH: if (is_ident(c)) n = ST_DONE;
			ST_DOL_DIG: if (is_digit(c)) n = ST_DOL_DIG;
			default: n = ST_FAIL;
		endcase
		return n;
	endfunction

	function automatic logic accepting(input parse_state_t s);
		logic a;
		unique case (s)
			ST_START, ST_EQ, ST_LBR, ST_AT, ST_ID_FIRST, ST_DOL, ST_FAIL: a = 1'b0;
			default: a = 1'b1;
		endcase
		return a;
	endfunction

endpackage

### rtl/core/snc_item_if.sv
// ----------------------------------------------------------------------------
// Symbol name checker input channel
// One byte of a name, or an end-of-name marker, per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface snc_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_name;

	modport source (output valid, output ch, output end_of_name, input ready);
	modport sink (input valid, input ch, input end_of_name, output ready);
endinterface

### rtl/core/snc_result_if.sv
// ----------------------------------------------------------------------------
// Symbol name checker result channel
// One verdict per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface snc_result_if;
	logic valid;
	logic ready;
	logic is_plain_name;

	modport source (output valid, output is_plain_name, input ready);
	modport sink (input valid, input is_plain_name, output ready);
endinterface

### rtl/core/symbol_name_checker.sv
// The verdict is registered and appears in the cycle after the end-of-name beat is taken.
// One input beat per cycle when the result side does not stall; the parser makes one transition per byte.
// Input is taken whenever the result register is empty or drains in that cycle.
// Reset puts the parser in its start state, clears the reject flag and
// empties the result register.
// ----------------------------------------------------------------------------
// Symbol name checker
// Byte-serial parser that tells whether a name is a plain symbol name.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module symbol_name_checker (
	input  logic           clk,
	input  logic           arst_n,
	snc_item_if.sink       item,
	snc_result_if.source   result
);

	snc_pkg::parse_state_t state_q;
	snc_pkg::parse_state_t state_nxt;
	logic                  rejected_q;
	logic                  res_valid_q;
	logic                  res_plain_q;
	logic                  take;
	logic                  verdict;

	assign item.ready = !res_valid_q || result.ready;
	assign take       = item.valid && item.ready;

	always_comb begin
		state_nxt = snc_pkg::next_state(state_q, item.ch);
		verdict   = !rejected_q && snc_pkg::accepting(state_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= snc_pkg::ST_START;
			rejected_q <= 1'b0;
		end else if (take) begin
			if (item.end_of_name) begin
				state_q    <= snc_pkg::ST_START;
				rejected_q <= 1'b0;
			end else if (!rejected_q) begin
				// A zero byte or a dead transition poisons the rest of the name.
				if ((item.ch == snc_pkg::CH_NUL) || (state_nxt == snc_pkg::ST_FAIL)) begin
					rejected_q <= 1'b1;
				end else begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && item.end_of_name) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.end_of_name) begin
			res_plain_q <= verdict;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.is_plain_name = res_plain_q;

endmodule

### rtl/core/snc_checker.sv
// ----------------------------------------------------------------------------
// Symbol name checker port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "symbol_name_checker_macros.svh"

module snc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       item_end,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_plain
);

	logic item_end_beat;

	assign item_end_beat = item_valid && item_ready && item_end;

	// A stalled result keeps its value.
	`SNC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_plain), "result changed while stalled")

	// Every end-of-name beat yields a verdict in the following cycle.
	`SNC_ASSERT_NEXT(a_end_gives_result, clk, arst_n, item_end_beat, res_valid, "end beat without a verdict")

	// A fresh verdict is only shown after an end-of-name beat.
	`SNC_ASSERT_SAME(a_no_spurious_result, clk, arst_n, res_valid && !$past(res_valid && !res_ready), $past(item_end_beat), "verdict without an end beat")

	// Two end beats in a row: the second name is empty and must be rejected.
	`SNC_ASSERT_NEXT(a_empty_rejected, clk, arst_n, item_end_beat ##1 item_end_beat, !res_plain, "empty name accepted")

endmodule

bind symbol_name_checker snc_checker u_snc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.item_end   (item.end_of_name),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_plain  (result.is_plain_name)
);

### tb/sv/symbol_name_checker_test.sv
// ----------------------------------------------------------------------------
// Symbol name checker testbench
// Sends symbol names one byte per beat, each name closed by an end beat. A
// scoreboard tracks the parser state beat by beat and predicts every verdict.
// A short directed set comes first, then random names: operators,
// identifiers, instance and global variables, damaged names and raw noise.
// Both sides insert random gaps, and the result side does one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module symbol_name_checker_test;
	import snc_pkg::*;

	// Noise names are not counted here and add roughly another tenth on top.
	localparam int RANDOM_BEATS      = 960;
	localparam int LONG_HOLD_AFTER   = 60;
	localparam int LONG_HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES       = 10;
	localparam logic [7:0] CH_A_UP   = 8'h41;
	localparam logic [7:0] CH_A_LO   = 8'h61;

	typedef struct packed {
		logic [7:0] ch;
		logic       eon;
	} name_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	snc_item_if   item_ch();
	snc_result_if verdict_ch();

	symbol_name_checker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (verdict_ch)
	);

	name_beat_t   name_beats[$];
	logic         verdicts_due[$];
	logic [7:0]   name_buf[$];
	string        op_names[];
	string        dollar_punct;

	parse_state_t parse_st;
	logic         name_rejected;

	int   mismatches = 0;
	int   verdicts_checked;
	int   send_gap;
	int   send_quiet;
	int   recv_stall;
	int   recv_quiet;
	logic long_hold_done;

	always #5 clk = ~clk;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_A_UP && c <= CH_A_UP + 8'd25) || (c >= CH_A_LO && c <= CH_A_LO + 8'd25);
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
	endfunction

	function automatic logic is_word_head(input logic [7:0] c);
		return is_letter(c) || c == CH_USCR;
	endfunction

	function automatic logic is_word_body(input logic [7:0] c);
		return is_word_head(c) || is_numeral(c);
	endfunction

	// One parser transition; ST_FAIL means the name can no longer be plain.
	function automatic parse_state_t next_parse_state(input parse_state_t s, input logic [7:0] c);
		parse_state_t n;
		n = ST_FAIL;
		case (s)
			ST_START: begin
				case (c)
					CH_DOL: n = ST_DOL;
					CH_AT: n = ST_AT;
					CH_LT: n = ST_LT;
					CH_GT: n = ST_GT;
					CH_EQ: n = ST_EQ;
					CH_STAR: n = ST_STAR;
					CH_BANG: n = ST_BANG;
					CH_PLUS, CH_DASH: n = ST_PM;
					CH_BAR: n = ST_BAR;
					CH_AMP: n = ST_AMP;
					CH_CARET, CH_SLASH, CH_PCT, CH_TILDE, CH_BTICK: n = ST_DONE;
					CH_LBR: n = ST_LBR;
					default: begin
						if (c >= CH_A_UP && c <= CH_A_UP + 8'd25) n = ST_ID_CONST;
						else if (is_word_head(c)) n = ST_ID_LOCAL;
					end
				endcase
			end
			ST_LT: begin
				if (c == CH_LT) n = ST_DONE;
				else if (c == CH_EQ) n = ST_LE;
			end
			ST_LE: if (c == CH_GT) n = ST_DONE;
			ST_GT: if (c == CH_GT || c == CH_EQ) n = ST_DONE;
			ST_EQ: begin
				if (c == CH_TILDE) n = ST_DONE;
				else if (c == CH_EQ) n = ST_EQEQ;
			end
			ST_EQEQ: if (c == CH_EQ) n = ST_DONE;
			ST_STAR: if (c == CH_STAR) n = ST_DONE;
			ST_BANG: if (c == CH_EQ || c == CH_TILDE) n = ST_DONE;
			ST_PM: if (c == CH_AT) n = ST_DONE;
			ST_BAR: if (c == CH_BAR) n = ST_DONE;
			ST_AMP: if (c == CH_AMP) n = ST_DONE;
			ST_LBR: if (c == CH_RBR) n = ST_BRK;
			ST_BRK: if (c == CH_EQ) n = ST_DONE;
			ST_ID_LOCAL: begin
				if (is_word_body(c)) n = ST_ID_LOCAL;
				else if (c == CH_BANG || c == CH_QUES || c == CH_EQ) n = ST_DONE;
			end
			ST_ID_CONST: if (is_word_body(c)) n = ST_ID_CONST;
			ST_AT: begin
				if (c == CH_AT) n = ST_ID_FIRST;
				else if (is_word_head(c)) n = ST_ID_CONST;
			end
			ST_ID_FIRST: if (is_word_head(c)) n = ST_ID_CONST;
			ST_DOL: begin
				case (c)
					CH_TILDE, CH_STAR, CH_DOL, CH_QUES, CH_BANG, CH_AT, CH_SLASH,
					CH_BSL, CH_SEMI, CH_COMMA, CH_DOT, CH_EQ, CH_COLON, CH_LT,
					CH_GT, CH_DQUOT, CH_AMP, CH_BTICK, CH_SQUOT, CH_PLUS,
					CH_ZERO: n = ST_DONE;
					CH_DASH: n = ST_DOL_DASH;
					default: begin
						if (is_numeral(c)) n = ST_DOL_DIG;
						else if (is_word_head(c)) n = ST_ID_CONST;
					end
				endcase
			end
			ST_DOL_DASH: if (is_word_body(c)) n = ST_DONE;
			ST_DOL_DIG: if (is_numeral(c)) n = ST_DOL_DIG;
			default: n = ST_FAIL;
		endcase
		return n;
	endfunction

	// Mostly short gaps, a few long ones, none at all during a quiet stretch.
	function automatic int random_gap(input int quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet != 0 || r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] word_char(input logic allow_digit);
		int r;
		r = $urandom_range(0, allow_digit ? 62 : 52);
		if (r < 26) return CH_A_LO + 8'(r);
		if (r < 52) return CH_A_UP + 8'(r - 26);
		if (r == 52) return CH_USCR;
		return CH_ZERO + 8'(r - 53);
	endfunction

	function automatic logic [7:0] pick_dollar_punct();
		int r;
		r = $urandom_range(0, dollar_punct.len());
		if (r == dollar_punct.len()) return CH_BTICK;
		return dollar_punct[r];
	endfunction

	task automatic queue_name();
		name_beat_t beat;
		foreach (name_buf[i]) begin
			beat.ch = name_buf[i];
			beat.eon = 1'b0;
			name_beats.push_back(beat);
		end
		beat.ch = 8'($urandom_range(0, 255));
		beat.eon = 1'b1;
		name_beats.push_back(beat);
	endtask

	task automatic queue_text(input string s);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
		queue_name();
	endtask

	task automatic wait_idle();
		while (name_beats.size() != 0 || item_ch.valid || verdicts_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic compose_name(output logic is_noise);
		int    kind;
		int    pos;
		string op;
		kind = $urandom_range(0, 99);
		name_buf.delete();
		is_noise = kind < 12;
		if (kind < 12) begin
			repeat ($urandom_range(0, 6)) name_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 32) begin
			pos = $urandom_range(0, op_names.size());
			if (pos == op_names.size()) begin
				name_buf.push_back(CH_BTICK);
			end else begin
				op = op_names[pos];
				for (int i = 0; i < op.len(); i++) name_buf.push_back(op[i]);
			end
		end else if (kind < 55) begin
			name_buf.push_back(word_char(1'b0));
			repeat ($urandom_range(0, 7)) name_buf.push_back(word_char(1'b1));
			if ($urandom_range(0, 9) < 4) begin
				case ($urandom_range(0, 2))
					0: name_buf.push_back(CH_BANG);
					1: name_buf.push_back(CH_QUES);
					default: name_buf.push_back(CH_EQ);
				endcase
			end
		end else if (kind < 68) begin
			name_buf.push_back(CH_AT);
			if ($urandom_range(0, 1) == 1) name_buf.push_back(CH_AT);
			name_buf.push_back(word_char(1'b0));
			repeat ($urandom_range(0, 5)) name_buf.push_back(word_char(1'b1));
		end else begin
			name_buf.push_back(CH_DOL);
			case ($urandom_range(0, 4))
				0: begin
					name_buf.push_back(word_char(1'b0));
					repeat ($urandom_range(0, 5)) name_buf.push_back(word_char(1'b1));
				end
				1: name_buf.push_back(pick_dollar_punct());
				2: name_buf.push_back(CH_DASH);
				3: begin
					name_buf.push_back(CH_DASH);
					name_buf.push_back(word_char(1'b1));
				end
				default: begin
					repeat ($urandom_range(1, 4))
						name_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end
			endcase
		end
		// Damage some well-formed names so the parser leaves its good paths late.
		if (!is_noise && $urandom_range(0, 99) < 22) begin
			pos = $urandom_range(0, name_buf.size() - 1);
			case ($urandom_range(0, 3))
				0: name_buf[pos] = 8'($urandom_range(0, 255));
				1: name_buf.insert(pos, 8'($urandom_range(0, 255)));
				2: void'(name_buf.pop_back());
				default: begin
					if ($urandom_range(0, 1) == 1) name_buf.push_back(pick_dollar_punct());
					else name_buf.push_back(word_char(1'b1));
				end
			endcase
		end
	endtask

	// Sender: offers queued beats and updates the scoreboard on each accepted beat.
	always @(posedge clk or negedge arst_n) begin : send_beats
		name_beat_t   beat;
		parse_state_t nxt;
		logic         verdict;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.ch <= '0;
			item_ch.end_of_name <= 1'b0;
			send_gap <= 0;
			send_quiet <= 0;
			parse_st = ST_START;
			name_rejected = 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				if (item_ch.end_of_name) begin
					case (parse_st)
						ST_START, ST_EQ, ST_LBR, ST_AT, ST_ID_FIRST, ST_DOL: verdict = 1'b0;
						default: verdict = !name_rejected;
					endcase
					verdicts_due.push_back(verdict);
					parse_st = ST_START;
					name_rejected = 1'b0;
				end else if (!name_rejected) begin
					if (item_ch.ch == CH_NUL) begin
						name_rejected = 1'b1;
					end else begin
						nxt = next_parse_state(parse_st, item_ch.ch);
						if (nxt == ST_FAIL) name_rejected = 1'b1;
						else parse_st = nxt;
					end
				end
			end
			if (item_ch.valid && !item_ch.ready) begin
				// The beat stays on the bus until it is taken.
			end else if (send_gap != 0) begin
				item_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (name_beats.size() != 0) begin
				beat = name_beats.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.ch <= beat.ch;
				item_ch.end_of_name <= beat.eon;
				send_gap <= random_gap(send_quiet);
				if (send_quiet != 0) send_quiet <= send_quiet - 1;
				else if ($urandom_range(0, 99) < 4) send_quiet <= $urandom_range(20, 80);
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver readiness, including one long hold-off that backs the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_ch.ready <= 1'b0;
			recv_stall <= 0;
			recv_quiet <= 0;
			long_hold_done <= 1'b0;
		end else if (recv_stall != 0) begin
			verdict_ch.ready <= 1'b0;
			recv_stall <= recv_stall - 1;
		end else if (!long_hold_done && verdicts_checked >= LONG_HOLD_AFTER) begin
			verdict_ch.ready <= 1'b0;
			recv_stall <= LONG_HOLD_CYCLES;
			long_hold_done <= 1'b1;
		end else begin
			verdict_ch.ready <= 1'b1;
			recv_stall <= random_gap(recv_quiet);
			if (recv_quiet != 0) recv_quiet <= recv_quiet - 1;
			else if ($urandom_range(0, 99) < 3) recv_quiet <= $urandom_range(20, 80);
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_verdicts
		logic want;
		if (!arst_n) begin
			verdicts_checked <= 0;
		end else if (verdict_ch.valid && verdict_ch.ready) begin
			verdicts_checked <= verdicts_checked + 1;
			if (verdicts_due.size() == 0) begin
				$display("%0t: verdict beat with none pending, expected none, got %0b",
					$time, verdict_ch.is_plain_name);
				mismatches++;
			end else begin
				want = verdicts_due.pop_front();
				if (verdict_ch.is_plain_name !== want) begin
					$display("%0t: is_plain_name mismatch, expected %0b, got %0b",
						$time, want, verdict_ch.is_plain_name);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		logic is_noise;
		int   counted;
		logic drained_mid;
		item_ch.valid = 1'b0;
		item_ch.ch = '0;
		item_ch.end_of_name = 1'b0;
		verdict_ch.ready = 1'b0;
		op_names = '{"<", "<<", "<=", "<=>", ">", ">>", ">=", "=~", "==", "===",
			"*", "**", "!", "!=", "!~", "+", "+@", "-", "-@", "|", "||", "&", "&&",
			"^", "/", "%", "~", "[]", "[]="};
		dollar_punct = "~*$?!@/\\;,.=:<>\"&'+0";
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Empty name, lone equals sign, an operator, a suffixed identifier,
		// a dash global, a NUL inside a name, a high byte and a class variable.
		queue_text("");
		queue_text("=");
		queue_text("[]=");
		queue_text("ab?");
		queue_text("$-w");
		name_buf.delete();
		name_buf.push_back(CH_A_LO);
		name_buf.push_back(CH_NUL);
		name_buf.push_back(CH_A_LO + 8'd1);
		queue_name();
		name_buf.delete();
		name_buf.push_back(8'hFF);
		queue_name();
		queue_text("@@x");
		wait_idle();

		counted = 0;
		drained_mid = 1'b0;
		while (counted < RANDOM_BEATS) begin
			compose_name(is_noise);
			queue_name();
			if (!is_noise) counted += name_buf.size() + 1;
			// The sender goes quiet once until every verdict has come back.
			if (!drained_mid && counted >= RANDOM_BEATS / 2) begin
				drained_mid = 1'b1;
				wait_idle();
			end
		end
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("[symbol_name_checker] OK");
		else $display("[symbol_name_checker] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[symbol_name_checker] ERROR");
		$finish;
	end

endmodule
